// File: rtl/set_assoc_lru_byte_cache_unit_defines.svh
// Assertion macros for the set-associative byte cache.
// Included by modules that check their own control logic; needs clk_i and rst_ni in scope.
`ifndef SET_ASSOC_LRU_BYTE_CACHE_UNIT_DEFINES_SVH
`define SET_ASSOC_LRU_BYTE_CACHE_UNIT_DEFINES_SVH

// A property checked at every clock edge outside reset.
`define SALBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A property checked at every clock edge, reset included.
`define SALBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/salbc_pkg.sv
// Shared constants for the set-associative byte cache.
// Used by the top level; depends on nothing else.
package salbc_pkg;

  // Default geometry.
  localparam int unsigned DefSets      = 128;
  localparam int unsigned DefWays      = 4;
  localparam int unsigned DefLineBytes = 64;
  localparam int unsigned DefAddrBits  = 18;

  // Fixed field widths.
  localparam int unsigned DataW  = 8;
  localparam int unsigned CountW = 32;

endpackage

// File: rtl/set_assoc_lru_byte_cache_unit.sv
// Top level of the set-associative write-back byte cache with true LRU replacement.
// Depends on salbc_pkg, salbc_ram and set_assoc_lru_byte_cache_unit_defines.svh.
//
// Usage: each input beat on s_axis is one byte access (tuser = 1 for a write).
// Each beat yields exactly one output beat on m_axis carrying the byte at the
// address after the access, a hit flag and the wrapping access and miss counters.
// A write hit passes through the metadata, access and response states before the
// result register loads, and a read hit adds a read-data state after the access;
// s_axis_tready rises on the edge that loads the result register. A miss into a
// free way adds a line refill from the backing memory, and a miss into a full
// set adds a whole line writeback of the victim before the refill. The copies run
// one byte per cycle over the single read port of the line and backing memories.
// One access is handled at a time; the next beat is taken once the previous
// result has moved into the output register.
// Reset: after rst_ni rises the block runs a clearing pass of 2^ADDR_BITS
// cycles (262144 by default) that zeroes the backing memory and the set
// metadata; s_axis_tready stays low during that pass.
// Stall: a held result stays in the output register while m_axis_tready is low;
// a finished access waits behind it and no new beat is taken until it moves.
`include "set_assoc_lru_byte_cache_unit_defines.svh"

module set_assoc_lru_byte_cache_unit #(
  parameter int unsigned SETS       = salbc_pkg::DefSets,
  parameter int unsigned WAYS       = salbc_pkg::DefWays,
  parameter int unsigned LINE_BYTES = salbc_pkg::DefLineBytes,
  parameter int unsigned ADDR_BITS  = salbc_pkg::DefAddrBits
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // address [ADDR_BITS-1:0], write_data [ADDR_BITS+7:ADDR_BITS], zero padding
  input  logic [((ADDR_BITS+salbc_pkg::DataW+7)/8)*8-1:0] s_axis_tdata,
  // op (0 read, 1 write)
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // read_data [7:0], hit [8], access_count [40:9], miss_count [72:41], zero padding
  output logic [((salbc_pkg::DataW+1+2*salbc_pkg::CountW+7)/8)*8-1:0] m_axis_tdata
);
  import salbc_pkg::*;

  localparam int unsigned OffW   = $clog2(LINE_BYTES);
  localparam int unsigned SetW   = $clog2(SETS);
  localparam int unsigned WayW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned TagW   = ADDR_BITS - SetW - OffW;
  localparam int unsigned AgeW   = WayW;
  localparam int unsigned FillW  = $clog2(WAYS + 1);
  localparam int unsigned EntW   = TagW + AgeW;
  localparam int unsigned MetaW  = FillW + WAYS * EntW;
  localparam int unsigned LineAW = SetW + WayW + OffW;
  localparam int unsigned OutW   = ((DataW + 1 + 2 * CountW + 7) / 8) * 8;
  localparam int unsigned PadW   = OutW - (DataW + 1 + 2 * CountW);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_META, S_WB, S_FILL, S_ACCESS, S_RDATA, S_RESP
  } state_e;

  state_e                 state_q;
  logic [ADDR_BITS-1:0]   clr_q;
  logic                   op_q;
  logic [TagW-1:0]        tag_q, old_tag_q;
  logic [SetW-1:0]        set_q;
  logic [OffW-1:0]        off_q;
  logic [DataW-1:0]       wd_q, rd_q;
  logic [WayW-1:0]        way_q;
  logic                   hit_q;
  logic [OffW:0]          k_q;
  logic [CountW-1:0]      acc_q, miss_q;
  logic                   out_valid_q;
  logic [OutW-1:0]        out_data_q;

  logic                   in_beat;
  logic                   out_load;
  logic [OffW-1:0]        k_prev;

  // Metadata memory ports.
  logic                   meta_we, meta_re;
  logic [SetW-1:0]        meta_waddr, meta_raddr;
  logic [MetaW-1:0]       meta_wdata, meta_rdata;

  // Line data memory ports.
  logic                   line_we, line_re;
  logic [LineAW-1:0]      line_waddr, line_raddr;
  logic [DataW-1:0]       line_wdata, line_rdata;

  // Backing memory ports.
  logic                   back_we, back_re;
  logic [ADDR_BITS-1:0]   back_waddr, back_raddr;
  logic [DataW-1:0]       back_wdata, back_rdata;

  // Lookup results.
  logic [TagW-1:0]        tags [WAYS];
  logic [AgeW-1:0]        ages [WAYS];
  logic [AgeW-1:0]        new_ages [WAYS];
  logic [FillW-1:0]       fill, fill_new;
  logic                   hit_c, full_c;
  logic [WayW-1:0]        hit_way, victim, sel_way;
  logic [AgeW-1:0]        ref_age;

  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign k_prev        = OffW'(k_q - 1'b1);
  assign out_load      = (state_q == S_RESP) && (!out_valid_q || m_axis_tready);

  // Decode the set metadata and work out the LRU update.
  always_comb begin
    fill    = meta_rdata[FillW-1:0];
    hit_c   = 1'b0;
    hit_way = '0;
    victim  = '0;
    for (int unsigned v = 0; v < WAYS; v++) begin
      tags[v] = meta_rdata[FillW + v*EntW +: TagW];
      ages[v] = meta_rdata[FillW + v*EntW + TagW +: AgeW];
    end
    for (int unsigned v = 0; v < WAYS; v++) begin
      if (!hit_c && (FillW'(v) < fill) && (tags[v] == tag_q)) begin
        hit_c   = 1'b1;
        hit_way = WayW'(v);
      end
    end
    for (int unsigned v = 1; v < WAYS; v++) begin
      if (ages[v] > ages[victim]) begin
        victim = WayW'(v);
      end
    end
    full_c = (fill >= FillW'(WAYS));
    if (hit_c) begin
      fill_new = fill;
      sel_way  = hit_way;
      ref_age  = ages[hit_way];
    end else if (!full_c) begin
      fill_new = fill + 1'b1;
      sel_way  = WayW'(fill);
      ref_age  = AgeW'(fill);
    end else begin
      fill_new = fill;
      sel_way  = victim;
      ref_age  = ages[victim];
    end
    meta_wdata = '0;
    meta_wdata[FillW-1:0] = fill_new;
    for (int unsigned v = 0; v < WAYS; v++) begin
      if (WayW'(v) == sel_way) begin
        new_ages[v] = '0;
      end else if ((FillW'(v) < fill_new) && (ages[v] < ref_age)) begin
        new_ages[v] = ages[v] + 1'b1;
      end else begin
        new_ages[v] = ages[v];
      end
      meta_wdata[FillW + v*EntW +: TagW] = (WayW'(v) == sel_way) ? tag_q : tags[v];
      meta_wdata[FillW + v*EntW + TagW +: AgeW] = new_ages[v];
    end
    if (state_q == S_CLEAR) begin
      meta_wdata = '0;
    end
  end

  // Memory port steering per state.
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = set_q;
    meta_re    = in_beat;
    meta_raddr = s_axis_tdata[OffW +: SetW];
    line_we    = 1'b0;
    line_waddr = {set_q, way_q, off_q};
    line_wdata = wd_q;
    line_re    = 1'b0;
    line_raddr = {set_q, way_q, off_q};
    back_we    = 1'b0;
    back_waddr = {old_tag_q, set_q, k_prev};
    back_wdata = line_rdata;
    back_re    = 1'b0;
    back_raddr = {tag_q, set_q, k_q[OffW-1:0]};
    case (state_q)
      S_CLEAR: begin
        back_we    = 1'b1;
        back_waddr = clr_q;
        back_wdata = '0;
        meta_we    = ({1'b0, clr_q} < (ADDR_BITS+1)'(SETS));
        meta_waddr = clr_q[SetW-1:0];
      end
      S_META: begin
        meta_we = 1'b1;
      end
      S_WB: begin
        line_re    = !k_q[OffW];
        line_raddr = {set_q, way_q, k_q[OffW-1:0]};
        back_we    = (k_q != '0);
      end
      S_FILL: begin
        back_re    = !k_q[OffW];
        line_we    = (k_q != '0);
        line_waddr = {set_q, way_q, k_prev};
        line_wdata = back_rdata;
      end
      S_ACCESS: begin
        line_we = op_q;
        line_re = !op_q;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, counters and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      acc_q       <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_beat) begin
            op_q    <= s_axis_tuser;
            off_q   <= s_axis_tdata[OffW-1:0];
            set_q   <= s_axis_tdata[OffW +: SetW];
            tag_q   <= s_axis_tdata[OffW+SetW +: TagW];
            wd_q    <= s_axis_tdata[ADDR_BITS +: DataW];
            acc_q   <= acc_q + 1'b1;
            state_q <= S_META;
          end
        end
        S_META: begin
          hit_q     <= hit_c;
          way_q     <= sel_way;
          old_tag_q <= tags[victim];
          k_q       <= '0;
          if (hit_c) begin
            state_q <= S_ACCESS;
          end else begin
            miss_q  <= miss_q + 1'b1;
            state_q <= full_c ? S_WB : S_FILL;
          end
        end
        S_WB: begin
          if (k_q[OffW]) begin
            k_q     <= '0;
            state_q <= S_FILL;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_FILL: begin
          k_q <= k_q + 1'b1;
          if (k_q[OffW]) begin
            state_q <= S_ACCESS;
          end
        end
        S_ACCESS: begin
          rd_q    <= wd_q;
          state_q <= op_q ? S_RESP : S_RDATA;
        end
        S_RDATA: begin
          rd_q    <= line_rdata;
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (out_load) begin
            out_data_q <= {{PadW{1'b0}}, miss_q, acc_q, hit_q, rd_q};
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Set metadata: fill count, then tag and age per way.
  salbc_ram #(.Width(MetaW), .Depth(SETS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (meta_re),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  // Cached line bytes.
  salbc_ram #(.Width(DataW), .Depth(SETS * (2**WayW) * LINE_BYTES)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .re_i    (line_re),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  // Backing store behind the cache.
  salbc_ram #(.Width(DataW), .Depth(2**ADDR_BITS)) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (back_we),
    .waddr_i (back_waddr),
    .wdata_i (back_wdata),
    .re_i    (back_re),
    .raddr_i (back_raddr),
    .rdata_o (back_rdata)
  );

  // Self checks on the sequencer and counters.
  `SALBC_ASSERT(a_no_result_in_clear, (state_q == S_CLEAR) |-> !out_valid_q, "result during clear")
  `SALBC_ASSERT(a_acc_step, in_beat |=> (acc_q == $past(acc_q) + 1'b1), "access count step")
  `SALBC_ASSERT(a_hit_no_miss, (state_q == S_META && hit_c) |=> (miss_q == $past(miss_q)), "hit counted as miss")
  `SALBC_ASSERT(a_fill_bound, (state_q == S_META) |-> (fill <= FillW'(WAYS)), "fill count beyond ways")

endmodule

// File: rtl/salbc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package needed.
module salbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
